/* rtl/mfb_pkg.sv */
package mfb_pkg;

  // Channel and fixed-point widths
  localparam int CHAN_W = 8;
  localparam int NUM_CHAN = 3;
  localparam int T_W = 17;
  localparam int LERP_W = CHAN_W + T_W;
  localparam int MIX_W = 2 * CHAN_W;

  // Q16 interpolation constants
  localparam logic [T_W-1:0] Q16_ONE = 17'h10000;
  localparam logic [T_W-1:0] Q16_HALF = 17'h08000;

  // Mask weight constants
  localparam logic [CHAN_W-1:0] MASK_FULL = 8'hFF;
  localparam logic [CHAN_W-1:0] MIX_ROUND = 8'd127;
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BLEND_T     = 2'd0,
    CFG_MASK_ENABLE = 2'd1,
    CFG_SCENE_CUT   = 2'd2
  } cfg_idx_t;

endpackage

/* rtl/mfb_chan.sv */
// One color channel: Q16 lerp of prev/cur, then mix with cur by mask/255.
// Four register stages; the quotient by 255 is combinational off the last one.
module mfb_chan (
  input  logic                                 clk,
  input  logic [mfb_pkg::CHAN_W-1:0]           prev_chan,
  input  logic [mfb_pkg::CHAN_W-1:0]           cur_chan,
  input  logic [mfb_pkg::T_W-1:0]              t,
  input  logic [mfb_pkg::T_W-1:0]              t_inv,
  input  logic [mfb_pkg::CHAN_W-1:0]           mask,
  output logic [mfb_pkg::CHAN_W-1:0]           mix_chan
);

  // stage 1: lerp products
  logic [mfb_pkg::LERP_W-1:0] prod_p;
  logic [mfb_pkg::LERP_W-1:0] prod_c;
  logic [mfb_pkg::CHAN_W-1:0] cur1;
  logic [mfb_pkg::CHAN_W-1:0] mask1;
  // stage 2: rounded lerp
  logic [mfb_pkg::LERP_W-1:0] lerp_sum;
  logic [mfb_pkg::CHAN_W-1:0] lerp2;
  logic [mfb_pkg::CHAN_W-1:0] cur2;
  logic [mfb_pkg::CHAN_W-1:0] mask2;
  // stage 3: mix products
  logic [mfb_pkg::MIX_W-1:0]  prod_b;
  logic [mfb_pkg::MIX_W-1:0]  prod_m;
  // stage 4: rounded mix numerator
  logic [mfb_pkg::MIX_W-1:0]  mix_num;
  logic [mfb_pkg::MIX_W:0]    quot;

  assign lerp_sum = prod_p + prod_c + mfb_pkg::LERP_W'(mfb_pkg::Q16_HALF);

  always_ff @(posedge clk) begin
    prod_p  <= mfb_pkg::LERP_W'(prev_chan) * mfb_pkg::LERP_W'(t_inv);
    prod_c  <= mfb_pkg::LERP_W'(cur_chan) * mfb_pkg::LERP_W'(t);
    cur1    <= cur_chan;
    mask1   <= mask;

    lerp2   <= lerp_sum[16 +: mfb_pkg::CHAN_W];
    cur2    <= cur1;
    mask2   <= mask1;

    prod_b  <= mfb_pkg::MIX_W'(lerp2) * mfb_pkg::MIX_W'(mfb_pkg::MASK_FULL - mask2);
    prod_m  <= mfb_pkg::MIX_W'(cur2) * mfb_pkg::MIX_W'(mask2);

    mix_num <= prod_b + prod_m + mfb_pkg::MIX_W'(mfb_pkg::MIX_ROUND);
  end

  // x/255 == (x + (x >> 8) + 1) >> 8 for every x below 65535
  assign quot = (mfb_pkg::MIX_W + 1)'(mix_num)
              + (mfb_pkg::MIX_W + 1)'(mix_num[mfb_pkg::MIX_W-1:mfb_pkg::CHAN_W])
              + (mfb_pkg::MIX_W + 1)'(1);
  assign mix_chan = quot[mfb_pkg::MIX_W-1:mfb_pkg::CHAN_W];

endmodule

/* rtl/masked_frame_blend.sv */
// masked_frame_blend: per-pixel blend of a previous and a current ARGB pixel.
// Input: a pixel pair with its mask byte is taken on a clock edge with start
// high and busy low. busy stays low, so a new pixel can start every cycle.
// Output: out_pixel is valid for exactly one cycle while done is high; the
// receiver has no way to stall, and every result is taken that cycle.
// Throughput: one pixel per clock through the five-stage pipeline (two
// multiply stages, two add stages, one output register), all stages
// free-running; done is registered in step with out_pixel.
// Config: cfg_valid/cfg_ready write channel, cfg_ready is always high.
// Index 0 blend_t (Q16 time, saturated at 1.0 on write), 1 mask_enable,
// 2 scene_cut. Write only while no pixel is in flight.
// Scene cut or an enabled full mask passes the current pixel unchanged;
// otherwise the result carries alpha 0xFF.
// Reset: synchronous rst clears the config and empties the pipeline; pixels
// in flight are dropped.
module masked_frame_blend (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [31:0]                  prev_pixel,
  input  logic [31:0]                  cur_pixel,
  input  logic [7:0]                   mask_weight,
  output logic                         done,
  output logic [31:0]                  out_pixel,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [mfb_pkg::T_W-1:0]      cfg_data
);

  localparam int DEPTH = 4;

  logic [mfb_pkg::T_W-1:0]    blend_t;
  logic [mfb_pkg::T_W-1:0]    blend_t_inv;
  logic [mfb_pkg::T_W-1:0]    t_clamped;
  logic                       mask_enable;
  logic                       scene_cut;
  logic                       accept;
  logic [mfb_pkg::CHAN_W-1:0] mask_eff;
  logic                       raw_in;
  logic [DEPTH-1:0]           valid;
  logic [DEPTH-1:0]           raw;
  logic [31:0]                cur_q [DEPTH];
  logic [23:0]                mixed;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Config registers, time saturated at 1.0
  assign t_clamped = (cfg_data > mfb_pkg::Q16_ONE) ? mfb_pkg::Q16_ONE : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_t     <= '0;
      blend_t_inv <= mfb_pkg::Q16_ONE;
      mask_enable <= 1'b0;
      scene_cut   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mfb_pkg::CFG_BLEND_T: begin
          blend_t     <= t_clamped;
          blend_t_inv <= mfb_pkg::Q16_ONE - t_clamped;
        end
        mfb_pkg::CFG_MASK_ENABLE: mask_enable <= cfg_data[0];
        mfb_pkg::CFG_SCENE_CUT:   scene_cut   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pass-through decision at entry
  assign mask_eff = mask_enable ? mask_weight : '0;
  assign raw_in   = scene_cut || (mask_eff == mfb_pkg::MASK_FULL);

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      done  <= 1'b0;
    end else begin
      valid <= {valid[DEPTH-2:0], accept};
      done  <= valid[DEPTH-1];
    end
  end

  // Side data that travels with each pixel
  always_ff @(posedge clk) begin
    raw      <= {raw[DEPTH-2:0], raw_in};
    cur_q[0] <= cur_pixel;
    for (int i = 1; i < DEPTH; i++) begin
      cur_q[i] <= cur_q[i-1];
    end
  end

  // Color channel datapaths
  for (genvar g = 0; g < mfb_pkg::NUM_CHAN; g++) begin : g_chan
    mfb_chan u_chan (
      .clk       (clk),
      .prev_chan (prev_pixel[g*mfb_pkg::CHAN_W +: mfb_pkg::CHAN_W]),
      .cur_chan  (cur_pixel[g*mfb_pkg::CHAN_W +: mfb_pkg::CHAN_W]),
      .t         (blend_t),
      .t_inv     (blend_t_inv),
      .mask      (mask_eff),
      .mix_chan  (mixed[g*mfb_pkg::CHAN_W +: mfb_pkg::CHAN_W])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    out_pixel <= raw[DEPTH-1] ? cur_q[DEPTH-1] : {mfb_pkg::ALPHA_OPAQUE, mixed};
  end

  // Every result comes from an earlier input transfer
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 5))
    else $error("result without a matching input transfer");

  // Alpha is opaque unless the current pixel was passed through
  a_alpha_source: assert property (@(posedge clk) disable iff (rst)
    (done && out_pixel[31:24] != mfb_pkg::ALPHA_OPAQUE)
      |-> out_pixel[31:24] == $past(cur_pixel[31:24], 5))
    else $error("alpha neither opaque nor from current pixel");

  // Scene cut at entry gives the raw current pixel
  a_scene_cut_raw: assert property (@(posedge clk) disable iff (rst)
    (done && $past(scene_cut, 5)) |-> out_pixel == $past(cur_pixel, 5))
    else $error("scene cut did not pass the current pixel");

endmodule
